@@ hdl/swt_pkg.sv @@
// Shared types and constants for the shell word tokenizer.
`timescale 1ns / 1ps

package swt_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        K_CHAR = 2'd0,
        K_END  = 2'd1,
        K_LINE = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    // Quote context of the line
    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    // Character held back for a look at its successor
    typedef enum logic [1:0] {
        P_NONE = 2'd0,
        P_BSL  = 2'd1,
        P_DOL  = 2'd2
    } t_pend;

    // Output sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EMIT  = 2'd1,
        S_DIGIT = 2'd2
    } t_state;

    localparam int OUT_BITS     = 16;
    localparam int STATUS_BITS  = 32;
    localparam int DIGITS       = 10;
    localparam int BCD_BITS     = 4 * DIGITS;
    localparam int M_DATA_BITS  = ((OUT_BITS + 2 + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_DATA_BITS - OUT_BITS - 2;
    localparam int CFG_IDX_BITS = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXPAND = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STATUS = 1'b1;

    // Character codes
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PIPE   = 8'h7C;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_QUEST  = 8'h3F;
    localparam logic [7:0] C_USCORE = 8'h5F;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_LO_A   = 8'h61;
    localparam logic [7:0] C_LO_Z   = 8'h7A;
    localparam logic [7:0] C_UP_A   = 8'h41;
    localparam logic [7:0] C_UP_Z   = 8'h5A;

    // One result beat
    typedef struct packed {
        t_kind                kind;
        logic [OUT_BITS-1:0]  ch;
        logic                 var_mark;
        logic                 glob;
    } t_res;

    // Request to the binary to decimal unit
    typedef struct packed {
        logic                   start;
        logic [STATUS_BITS-1:0] mag;
    } t_bcd_req;

endpackage

@@ hdl/swt_bcd.sv @@
// Iterative shift-and-add-3 unit turning the status magnitude into decimal digits.
`timescale 1ns / 1ps

module swt_bcd (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  swt_pkg::t_bcd_req            i_req,
    output logic                         o_done,
    output logic [swt_pkg::BCD_BITS-1:0] o_bcd
);
    import swt_pkg::*;

    localparam int CNT_BITS = $clog2(STATUS_BITS + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [STATUS_BITS-1:0] r_bin, n_bin;
    logic [BCD_BITS-1:0]    r_bcd, n_bcd;
    logic [BCD_BITS-1:0]    w_adj;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                         : r_bcd[4*i +: 4];
        end
    end

    // Load on request, then shift one binary bit in per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_bin  = i_req.mag;
            n_bcd  = '0;
        end else if (r_busy) begin
            {n_bcd, n_bin} = {w_adj, r_bin} << 1;
            n_cnt = r_cnt + CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(STATUS_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

@@ hdl/shell_word_tokenizer.sv @@
// Top level: splits a command line into words, one result beat at a time.
// Results of a taken beat are registered into planned slots, then leave through the
// output register one per cycle while the receiver is ready; no new beat is taken
// until the last result is loaded. A status expansion waits on the shift-add-3 unit,
// then drops leading zeros, and its digits leave one per cycle while the receiver is ready.
// Reset (synchronous, active low) clears config, quote/word state and the sequencer.
`timescale 1ns / 1ps

module shell_word_tokenizer #(
    parameter int CHAR_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((CHAR_BITS+7)/8)*8-1:0]    i_s_tdata,  // ch
    input  logic                              i_s_tlast,  // end_of_line
    // master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [swt_pkg::M_DATA_BITS-1:0]   o_m_tdata,  // out_char, variable_mark,
                                                          // glob_expand
    output logic [1:0]                        o_m_tuser,  // kind
    output logic                              o_m_tlast,  // last
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [swt_pkg::STATUS_BITS-1:0]   i_cfg_data
);
    import swt_pkg::*;

    function automatic t_res mk_res(t_kind k, logic [OUT_BITS-1:0] c, logic v, logic g);
        t_res r;
        r.kind     = k;
        r.ch       = c;
        r.var_mark = v;
        r.glob     = g;
        return r;
    endfunction

    // Configuration
    logic                   r_expand;
    logic [STATUS_BITS-1:0] r_status;

    // Line state
    t_quote r_qm, n_qm;
    logic   r_ws, n_ws;
    logic   r_gs, n_gs;
    t_pend  r_pend, n_pend;

    // Planned results of the accepted beat
    t_res       p_slot [0:2];
    logic [1:0] p_cnt;
    logic       p_stat;

    // Sequencer
    t_state     r_state, n_state;
    t_res       r_slot [0:2];
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       r_stat;
    logic [3:0] r_dig;
    logic       r_nz;

    // Output register
    logic r_ovalid;
    t_res r_out;
    logic r_olast;

    logic                 w_acc;
    logic                 w_free;
    logic                 w_load;
    t_res                 w_out;
    logic                 w_olast;
    logic                 w_skip;
    logic [3:0]           w_digit;
    logic [CHAR_BITS-1:0] w_c;
    logic [OUT_BITS-1:0]  w_c16;
    t_bcd_req             w_req;
    logic                 w_bcd_done;
    logic [BCD_BITS-1:0]  w_bcd;

    logic is_sp, is_tab, is_sq, is_dq, is_dol, is_star, is_bsl, is_quest;
    logic is_esc, is_name;

    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_free      = !r_ovalid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Classify the incoming character
    assign w_c      = i_s_tdata[CHAR_BITS-1:0];
    assign w_c16    = OUT_BITS'(w_c);
    assign is_sp    = (w_c == CHAR_BITS'(C_SPACE));
    assign is_tab   = (w_c == CHAR_BITS'(C_TAB));
    assign is_sq    = (w_c == CHAR_BITS'(C_SQUOTE));
    assign is_dq    = (w_c == CHAR_BITS'(C_DQUOTE));
    assign is_dol   = (w_c == CHAR_BITS'(C_DOLLAR));
    assign is_star  = (w_c == CHAR_BITS'(C_STAR));
    assign is_bsl   = (w_c == CHAR_BITS'(C_BSLASH));
    assign is_quest = (w_c == CHAR_BITS'(C_QUEST));
    assign is_esc   = is_sp || is_tab || is_sq || is_dq || is_dol || is_star ||
                      (w_c == CHAR_BITS'(C_PIPE)) || (w_c == CHAR_BITS'(C_SEMI)) ||
                      (w_c == CHAR_BITS'(C_AMP));
    assign is_name  = ((w_c >= CHAR_BITS'(C_LO_A)) && (w_c <= CHAR_BITS'(C_LO_Z))) ||
                      ((w_c >= CHAR_BITS'(C_UP_A)) && (w_c <= CHAR_BITS'(C_UP_Z))) ||
                      (w_c == CHAR_BITS'(C_USCORE));

    // Plan the results of one beat and the line state it leaves
    always_comb begin
        p_slot[0] = mk_res(K_CHAR, '0, 1'b0, 1'b0);
        p_slot[1] = mk_res(K_CHAR, '0, 1'b0, 1'b0);
        p_slot[2] = mk_res(K_CHAR, '0, 1'b0, 1'b0);
        p_cnt     = 2'd0;
        p_stat    = 1'b0;
        n_qm      = r_qm;
        n_ws      = r_ws;
        n_gs      = r_gs;
        n_pend    = P_NONE;
        if (i_s_tlast) begin
            // flush a held character, then close the word and the line, or flag an open quote
            if (r_pend == P_BSL) begin
                p_slot[p_cnt] = mk_res(K_CHAR, OUT_BITS'(C_BSLASH), 1'b0, 1'b0);
                p_cnt = p_cnt + 2'd1;
            end else if (r_pend == P_DOL) begin
                p_slot[p_cnt] = mk_res(K_CHAR, OUT_BITS'(C_DOLLAR), 1'b0, 1'b0);
                p_cnt = p_cnt + 2'd1;
            end
            if (r_qm != Q_NONE) begin
                p_slot[p_cnt] = mk_res(K_ERR, '0, 1'b0, 1'b0);
                p_cnt = p_cnt + 2'd1;
            end else begin
                if (r_ws) begin
                    p_slot[p_cnt] = mk_res(K_END, '0, 1'b0, r_gs);
                    p_cnt = p_cnt + 2'd1;
                end
                p_slot[p_cnt] = mk_res(K_LINE, '0, 1'b0, 1'b0);
                p_cnt = p_cnt + 2'd1;
            end
            n_qm = Q_NONE;
            n_ws = 1'b0;
            n_gs = 1'b0;
        end else if (r_pend == P_BSL && is_esc) begin
            p_slot[0] = mk_res(K_CHAR, w_c16, 1'b0, 1'b0);
            p_cnt = 2'd1;
        end else if (r_pend == P_DOL && is_quest && r_expand) begin
            // status digits come from the conversion unit; sign goes first
            p_stat = 1'b1;
            if (r_status[STATUS_BITS-1]) begin
                p_slot[0] = mk_res(K_CHAR, OUT_BITS'(C_MINUS), 1'b0, 1'b0);
                p_cnt = 2'd1;
            end
        end else begin
            if (r_pend == P_BSL) begin
                p_slot[p_cnt] = mk_res(K_CHAR, OUT_BITS'(C_BSLASH), 1'b0, 1'b0);
                p_cnt = p_cnt + 2'd1;
            end else if (r_pend == P_DOL) begin
                p_slot[p_cnt] = mk_res(K_CHAR, OUT_BITS'(C_DOLLAR), is_name, 1'b0);
                p_cnt = p_cnt + 2'd1;
            end
            if (r_qm == Q_NONE && (is_sp || is_tab)) begin
                // blank outside quotes ends any open word
                if (r_ws) begin
                    p_slot[p_cnt] = mk_res(K_END, '0, 1'b0, r_gs);
                    p_cnt = p_cnt + 2'd1;
                end
                n_ws = 1'b0;
                n_gs = 1'b0;
            end else begin
                n_ws = 1'b1;
                if (r_qm == Q_NONE && (is_sq || is_dq)) begin
                    n_qm = is_sq ? Q_SINGLE : Q_DOUBLE;
                end else if ((r_qm == Q_SINGLE && is_sq) || (r_qm == Q_DOUBLE && is_dq)) begin
                    n_qm = Q_NONE;
                end else if (is_bsl && r_qm != Q_SINGLE) begin
                    n_pend = P_BSL;
                end else if (is_dol && r_qm != Q_SINGLE) begin
                    n_pend = P_DOL;
                end else begin
                    if (r_qm == Q_NONE && is_star) begin
                        n_gs = 1'b1;
                    end
                    p_slot[p_cnt] = mk_res(K_CHAR, w_c16, 1'b0, 1'b0);
                    p_cnt = p_cnt + 2'd1;
                end
            end
        end
    end

    // Start a conversion of the status magnitude
    assign w_req.start = w_acc && p_stat;
    assign w_req.mag   = r_status[STATUS_BITS-1] ? (STATUS_BITS'(0) - r_status) : r_status;

    swt_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_bcd_done),
        .o_bcd   (w_bcd)
    );

    assign w_digit = w_bcd[{r_dig, 2'b00} +: 4];
    assign w_skip  = !r_nz && (w_digit == 4'd0) && (r_dig != 4'd0);

    // Sequencer outputs: pick the next beat for the output register
    always_comb begin
        w_load  = 1'b0;
        w_out   = mk_res(K_CHAR, '0, 1'b0, 1'b0);
        w_olast = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_load = 1'b0;
            end
            S_EMIT: begin
                w_load  = w_free;
                w_out   = r_slot[r_idx];
                w_olast = (r_idx == (r_cnt - 2'd1)) && !r_stat;
            end
            S_DIGIT: begin
                w_load  = w_free && w_bcd_done && !w_skip;
                w_out   = mk_res(K_CHAR, OUT_BITS'(C_ZERO) + OUT_BITS'(w_digit), 1'b0, 1'b0);
                w_olast = (r_dig == 4'd0);
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (p_cnt != 2'd0) begin
                        n_state = S_EMIT;
                    end else if (p_stat) begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_load && (r_idx == (r_cnt - 2'd1))) begin
                    n_state = r_stat ? S_DIGIT : S_IDLE;
                end
            end
            S_DIGIT: begin
                if (w_load && (r_dig == 4'd0)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expand <= 1'b0;
            r_status <= '0;
            r_qm     <= Q_NONE;
            r_ws     <= 1'b0;
            r_gs     <= 1'b0;
            r_pend   <= P_NONE;
            r_state  <= S_IDLE;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
            r_stat   <= 1'b0;
            r_dig    <= 4'd0;
            r_nz     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_EXPAND: r_expand <= i_cfg_data[0];
                    CFG_STATUS: r_status <= i_cfg_data;
                    default:    r_status <= r_status;
                endcase
            end
            // take a beat
            if (w_acc) begin
                r_qm   <= n_qm;
                r_ws   <= n_ws;
                r_gs   <= n_gs;
                r_pend <= n_pend;
                r_cnt  <= p_cnt;
                r_idx  <= 2'd0;
                r_stat <= p_stat;
                r_dig  <= 4'(DIGITS - 1);
                r_nz   <= 1'b0;
            end
            // advance through planned beats
            if (r_state == S_EMIT && w_load) begin
                r_idx <= r_idx + 2'd1;
            end
            // walk the digits, dropping leading zeros
            if (r_state == S_DIGIT && w_bcd_done) begin
                if (w_skip) begin
                    r_dig <= r_dig - 4'd1;
                end else if (w_load) begin
                    r_nz <= 1'b1;
                    if (r_dig != 4'd0) begin
                        r_dig <= r_dig - 4'd1;
                    end
                end
            end
            // hold the output until taken
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_slot[0] <= p_slot[0];
            r_slot[1] <= p_slot[1];
            r_slot[2] <= p_slot[2];
        end
        if (w_load) begin
            r_out   <= w_out;
            r_olast <= w_olast;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{M_PAD_BITS{1'b0}}, r_out.glob, r_out.var_mark, r_out.ch};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_olast;

    // End of line always leaves the line state at rest
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_tlast) |=> (r_qm == Q_NONE && !r_ws && !r_gs && r_pend == P_NONE))
        else $error("line state not cleared after end of line");

    // Glob flag only ever rides on a word end
    a_glob_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[OUT_BITS+1]) |-> (r_out.kind == K_END))
        else $error("glob flag on a beat that is not a word end");

    // Digits follow planned beats only for a status expansion
    a_digit_from_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_DIGIT) |-> r_stat)
        else $error("digit phase entered without a status request");

    // Nothing is loaded for output while no item is in flight
    a_no_idle_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_state != S_IDLE))
        else $error("result loaded while idle");

endmodule

@@ sim/shell_word_tokenizer_tb.sv @@
// Self-checking testbench for the shell word tokenizer: random lines, stalls and status settings.
`timescale 1ns / 1ps

module shell_word_tokenizer_tb;

    import swt_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 64;    // status unit plus sign and ten digits, with margin
    localparam int HOLD_CYCLES   = 240;
    localparam int IDLE_PCT      = 20;

    // One expected result beat
    typedef struct packed {
        t_kind       kind;
        logic [15:0] ch;
        logic        var_mark;
        logic        glob;
        logic        last;
    } t_token;

    // Predicts the token stream of each accepted character and checks the output against it
    class token_scoreboard;
        logic        expand_on;
        logic [31:0] status_val;
        t_quote      quote_st;
        t_pend       held_st;
        logic        word_open;
        logic        star_seen;
        t_token      step_q[$];
        t_token      token_q[$];
        int          errors;

        function new();
            expand_on  = 1'b0;
            status_val = '0;
            quote_st   = Q_NONE;
            held_st    = P_NONE;
            word_open  = 1'b0;
            star_seen  = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
            if (idx == CFG_EXPAND)
                expand_on = val[0];
            else
                status_val = val;
        endfunction

        function int outstanding();
            return token_q.size();
        endfunction

        function void add(t_kind k, logic [15:0] c, logic vm, logic gl);
            t_token t;
            t.kind     = k;
            t.ch       = c;
            t.var_mark = vm;
            t.glob     = gl;
            t.last     = 1'b0;
            step_q.push_back(t);
        endfunction

        function logic escapable(logic [15:0] c);
            return c == C_SPACE || c == C_TAB || c == C_SQUOTE || c == C_DQUOTE ||
                   c == C_DOLLAR || c == C_STAR || c == C_PIPE || c == C_SEMI ||
                   c == C_AMP;
        endfunction

        function logic opens_name(logic [15:0] c);
            return (c >= C_LO_A && c <= C_LO_Z) || (c >= C_UP_A && c <= C_UP_Z) ||
                   c == C_USCORE;
        endfunction

        // Emit the signed decimal digits of the status, most significant first
        function void add_status();
            logic [31:0] mag;
            logic [3:0]  dig[10];
            int          n;
            mag = status_val;
            n   = 0;
            if (status_val[31]) begin
                add(K_CHAR, {8'h00, C_MINUS}, 1'b0, 1'b0);
                mag = 32'd0 - status_val;
            end
            while (n == 0 || (mag != 0 && n < 10)) begin
                dig[n] = 4'(mag % 10);
                mag    = mag / 10;
                n++;
            end
            while (n > 0) begin
                n--;
                add(K_CHAR, {8'h00, C_ZERO} + {12'h000, dig[n]}, 1'b0, 1'b0);
            end
        endfunction

        // Character with no pending backslash or dollar in front of it
        function void take_plain(logic [15:0] c);
            if (quote_st == Q_NONE && (c == C_SPACE || c == C_TAB)) begin
                if (word_open)
                    add(K_END, '0, 1'b0, star_seen);
                word_open = 1'b0;
                star_seen = 1'b0;
                return;
            end
            word_open = 1'b1;
            if (quote_st == Q_NONE && c == C_SQUOTE) begin
                quote_st = Q_SINGLE;
            end else if (quote_st == Q_NONE && c == C_DQUOTE) begin
                quote_st = Q_DOUBLE;
            end else if ((quote_st == Q_SINGLE && c == C_SQUOTE) ||
                         (quote_st == Q_DOUBLE && c == C_DQUOTE)) begin
                quote_st = Q_NONE;
            end else if (c == C_BSLASH && quote_st != Q_SINGLE) begin
                held_st = P_BSL;
            end else if (c == C_DOLLAR && quote_st != Q_SINGLE) begin
                held_st = P_DOL;
            end else begin
                if (quote_st == Q_NONE && c == C_STAR)
                    star_seen = 1'b1;
                add(K_CHAR, c, 1'b0, 1'b0);
            end
        endfunction

        function void note_item(logic [15:0] c, logic eol);
            t_pend  was;
            t_token t;
            was     = held_st;
            held_st = P_NONE;
            step_q.delete();
            if (eol) begin
                if (was == P_BSL)
                    add(K_CHAR, {8'h00, C_BSLASH}, 1'b0, 1'b0);
                else if (was == P_DOL)
                    add(K_CHAR, {8'h00, C_DOLLAR}, 1'b0, 1'b0);
                if (quote_st != Q_NONE) begin
                    add(K_ERR, '0, 1'b0, 1'b0);
                end else begin
                    if (word_open)
                        add(K_END, '0, 1'b0, star_seen);
                    add(K_LINE, '0, 1'b0, 1'b0);
                end
                quote_st  = Q_NONE;
                word_open = 1'b0;
                star_seen = 1'b0;
            end else if (was == P_BSL && escapable(c)) begin
                add(K_CHAR, c, 1'b0, 1'b0);
            end else if (was == P_DOL && c == C_QUEST && expand_on) begin
                add_status();
            end else begin
                if (was == P_BSL)
                    add(K_CHAR, {8'h00, C_BSLASH}, 1'b0, 1'b0);
                else if (was == P_DOL)
                    add(K_CHAR, {8'h00, C_DOLLAR}, opens_name(c), 1'b0);
                take_plain(c);
            end
            // Mark the final beat of this item and queue the lot
            foreach (step_q[i]) begin
                t      = step_q[i];
                t.last = (i == step_q.size() - 1);
                token_q.push_back(t);
            end
        endfunction

        function void miss(string field, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            errors++;
        endfunction

        function void check_token(t_kind k, logic [15:0] c, logic vm, logic gl, logic lst);
            t_token want;
            if (token_q.size() == 0) begin
                miss("unexpected beat kind", 16'hxxxx, {14'd0, k});
                return;
            end
            want = token_q.pop_front();
            if (k !== want.kind)       miss("kind", {14'd0, want.kind}, {14'd0, k});
            if (c !== want.ch)         miss("out_char", want.ch, c);
            if (vm !== want.var_mark)  miss("variable_mark", {15'd0, want.var_mark}, {15'd0, vm});
            if (gl !== want.glob)      miss("glob_expand", {15'd0, want.glob}, {15'd0, gl});
            if (lst !== want.last)     miss("last", {15'd0, want.last}, {15'd0, lst});
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_s_tvalid  = 1'b0;
    logic                     o_s_tready;
    logic [15:0]              i_s_tdata   = '0;
    logic                     i_s_tlast   = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready  = 1'b0;
    logic [M_DATA_BITS-1:0]   o_m_tdata;
    logic [1:0]               o_m_tuser;
    logic                     o_m_tlast;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [STATUS_BITS-1:0]   i_cfg_data  = '0;

    token_scoreboard sb = new();
    logic [16:0]     line_q[$];      // {end_of_line, ch}
    int              cycle_cnt = 0;
    int              hold_left = 0;
    bit              hold_go   = 1'b0;
    bit              calm      = 1'b0;

    shell_word_tokenizer #(.CHAR_BITS(16)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (calm) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check every result beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_token(t_kind'(o_m_tuser), o_m_tdata[15:0], o_m_tdata[16],
                           o_m_tdata[17], o_m_tlast);
    end

    function automatic logic [15:0] special_char();
        case ($urandom_range(0, 11))
            0:       return 16'(C_SPACE);
            1:       return 16'(C_TAB);
            2:       return 16'(C_SQUOTE);
            3:       return 16'(C_DQUOTE);
            4:       return 16'(C_DOLLAR);
            5:       return 16'(C_STAR);
            6:       return 16'(C_PIPE);
            7:       return 16'(C_SEMI);
            8:       return 16'(C_AMP);
            9:       return 16'(C_QUEST);
            10:      return 16'(C_BSLASH);
            default: return 16'(C_USCORE);
        endcase
    endfunction

    function automatic logic [15:0] word_char();
        case ($urandom_range(0, 5))
            0:       return {8'h00, C_LO_A} + 16'($urandom_range(0, 25));
            1:       return {8'h00, C_UP_A} + 16'($urandom_range(0, 25));
            2:       return {8'h00, C_ZERO} + 16'($urandom_range(0, 9));
            3:       return 16'(C_PIPE);
            4:       return 16'(C_QUEST);
            default: return 16'(C_USCORE);
        endcase
    endfunction

    function automatic logic [15:0] any_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return word_char();
        if (r < 7)
            return special_char();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void put_ch(logic [15:0] c);
        line_q.push_back({1'b0, c});
    endfunction

    // ch is ignored on end of line, so let it wander
    function automatic void put_eol();
        line_q.push_back({1'b1, 16'($urandom_range(0, 65535))});
    endfunction

    // Mostly well-formed words with random content, some noise and open quotes
    task automatic build_line();
        int n_tok;
        int r;
        int k;
        n_tok = $urandom_range(1, 6);
        if ($urandom_range(0, 19) == 0)
            n_tok = 0;
        repeat (n_tok) begin
            r = $urandom_range(0, 99);
            if (r < 14) begin
                put_ch(16'(($urandom_range(0, 1) == 1) ? C_TAB : C_SPACE));
            end else if (r < 34) begin
                repeat ($urandom_range(1, 4)) put_ch(word_char());
            end else if (r < 42) begin
                put_ch(16'(C_STAR));
            end else if (r < 54) begin
                put_ch(16'(C_BSLASH));
                if ($urandom_range(0, 9) != 0)
                    put_ch(($urandom_range(0, 1) == 1) ? special_char() : any_char());
            end else if (r < 64) begin
                put_ch(16'(C_SQUOTE));
                repeat ($urandom_range(0, 3)) put_ch(any_char());
                put_ch(16'(C_SQUOTE));
            end else if (r < 74) begin
                put_ch(16'(C_DQUOTE));
                repeat ($urandom_range(0, 3)) begin
                    k = $urandom_range(0, 3);
                    if (k == 0) begin
                        put_ch(16'(C_DOLLAR));
                        put_ch(16'(C_QUEST));
                    end else if (k == 1) begin
                        put_ch(16'(C_BSLASH));
                        put_ch(special_char());
                    end else begin
                        put_ch(any_char());
                    end
                end
                put_ch(16'(C_DQUOTE));
            end else if (r < 86) begin
                put_ch(16'(C_DOLLAR));
                k = $urandom_range(0, 4);
                if (k < 2)
                    put_ch(16'(C_QUEST));
                else if (k == 2)
                    put_ch(word_char());
                else if (k == 3)
                    put_ch(any_char());
            end else if (r < 94) begin
                put_ch(any_char());
            end else begin
                put_ch(16'(($urandom_range(0, 1) == 1) ? C_SQUOTE : C_DQUOTE));
            end
        end
        put_eol();
    endtask

    // Offer one beat, with random idle cycles in front of it
    task automatic send_item(logic [15:0] c, logic eol);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= eol;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(c, eol);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_item(line_q[i][15:0], line_q[i][16]);
        line_q.delete();
    endtask

    // Drop valid, wait for every expected beat, then let the block go quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic expand, logic [31:0] status);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_EXPAND;
        i_cfg_data  <= {31'd0, expand};
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_EXPAND, {31'd0, expand});
        i_cfg_index <= CFG_STATUS;
        i_cfg_data  <= status;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_STATUS, status);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic expand, logic [31:0] status, int n_items,
                             bit quiet, bit squeeze);
        int sent;
        settle();
        write_config(expand, status);
        calm = quiet;
        if (squeeze)
            hold_go = 1'b1;
        sent = 0;
        while (sent < n_items) begin
            build_line();
            sent += line_q.size();
            send_line();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: glob star, escaped star, empty quotes, stray backslash,
        // variable mark, code extremes, literal dollar-question, dollar at end of line
        put_ch(16'(C_SPACE));
        put_ch(16'(C_STAR));
        put_ch(16'(C_BSLASH));
        put_ch(16'(C_STAR));
        put_ch(16'(C_SQUOTE));
        put_ch(16'(C_SQUOTE));
        put_ch(16'(C_BSLASH));
        put_ch(16'h0078);
        put_ch(16'(C_DOLLAR));
        put_ch(16'(C_USCORE));
        put_ch(16'hFFFF);
        put_ch(16'h0000);
        put_ch(16'(C_TAB));
        put_ch(16'(C_DOLLAR));
        put_ch(16'(C_QUEST));
        put_ch(16'(C_DOLLAR));
        put_eol();
        send_line();

        // Most negative status, backslash at end of line, open double quote
        settle();
        write_config(1'b1, 32'h8000_0000);
        put_ch(16'(C_DOLLAR));
        put_ch(16'(C_QUEST));
        put_ch(16'(C_BSLASH));
        put_eol();
        put_ch(16'(C_DQUOTE));
        put_ch(16'(C_BSLASH));
        put_ch(16'(C_DQUOTE));
        put_ch(16'(C_SQUOTE));
        put_eol();
        send_line();

        // Random lines across several settings
        run_phase(1'b1, 32'd0,          30, 1'b0, 1'b0);
        run_phase(1'b1, 32'h7FFF_FFFF,  30, 1'b1, 1'b0);
        run_phase(1'b1, 32'hFFFF_FFFF,  25, 1'b0, 1'b1);
        run_phase(1'b0, $urandom,       25, 1'b0, 1'b0);
        run_phase(1'b1, $urandom,       25, 1'b0, 1'b0);

        calm = 1'b0;
        settle();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
